// File: rtl/bmtp_pkg.sv
// Shared types and constants of the box-mean threshold point picker.
`timescale 1ns / 1ps

package bmtp_pkg;

    localparam int BMTP_MAX_WIDTH = 1024;

    localparam int FW_W    = 11;   // frame_width register
    localparam int FH_W    = 12;   // frame_height register
    localparam int THR_W   = 12;   // mean_threshold register
    localparam int CFG_W   = 12;   // widest register
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W   = 13;   // row counter runs up to height + 1
    localparam int POSX_W  = 10;
    localparam int POSY_W  = 12;
    localparam int HITS_W  = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_THRESHOLD = 2'd2;

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH    = 11'd640;
    localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT   = 12'd480;
    localparam logic [THR_W-1:0] RST_MEAN_THRESHOLD = 12'd2048;

    localparam logic [HITS_W-1:0] HIT_MAX = 22'h3FFFFF;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       is_flush;
    } t_bmtp_in;

    typedef struct packed {
        logic              decided;
        logic              above;
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
        logic [HITS_W-1:0] hits_so_far;
        logic              frame_done;
    } t_bmtp_out;

    // Per-item window control worked out from the raster position.
    typedef struct packed {
        logic              decide;
        logic              left;
        logic              right;
        logic              top;
        logic              bottom;
        logic              done;
        logic              clr_hits;
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
    } t_bmtp_ctl;

endpackage

// File: rtl/bmtp_if.sv
// Valid/ready stream interfaces for the pixel input and the result output.
`timescale 1ns / 1ps

interface bmtp_in_if import bmtp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_bmtp_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bmtp_out_if import bmtp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_bmtp_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/box_mean_threshold_point_picker.sv
// Top level: 3x3 clipped box mean over a raster stream with threshold decision.
`timescale 1ns / 1ps

// Takes one pixel transaction per clock unless stalled and returns exactly one
// result transaction per input via stage two and the output register. The first
// stage reads the two line buffers (one memory read port each) at the current
// column; the second shifts the 3x3 window, sums the in-frame neighbors, compares
// against the threshold and writes the line buffers back. Input ready drops only
// while a finished result waits at the output and the second stage is full.
// After each frame of width*height pixels, send width+1 flush transactions to
// drain the last row. Configuration is taken at any time but is meant to be
// written while the block is idle. No clearing pass is needed after reset.
module box_mean_threshold_point_picker import bmtp_pkg::*; #(
    parameter int MAX_WIDTH = BMTP_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bmtp_in_if.sink              i_pix,
    bmtp_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);

    // configuration
    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [THR_W-1:0] r_mean_threshold;

    // raster position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // line buffers
    logic [7:0] r_line_above     [0:MAX_WIDTH-1];
    logic [7:0] r_line_two_above [0:MAX_WIDTH-1];
    logic [7:0] r_rd_a1, r_rd_a2;

    // second stage
    logic             r_a_valid;
    logic [7:0]       r_a_p;
    logic [COL_W-1:0] r_a_col;
    logic             r_a_fwd;
    logic [7:0]       r_a_fa1, r_a_fa2;
    t_bmtp_ctl        r_a_ctl, n_ctl;

    logic [7:0]        r_win [0:2][0:2];   // [column old..new][row top..bottom]
    logic [7:0]        n_win [0:2][0:2];
    logic [HITS_W-1:0] r_hits, n_hits;

    // output register
    logic      r_o_valid;
    t_bmtp_out r_o, n_o;

    logic             in_acc, a_adv;
    logic [WW-1:0]    w;
    logic [FH_W-1:0]  h;
    logic [ROW_W-1:0] h_row, h1_row;
    logic             pos_rst, col_zero;
    logic [COL_W-1:0] col_e, x;
    logic [ROW_W-1:0] row_e;
    logic [ROW_W-1:0] y_full;
    logic [7:0]       p_in;
    logic [7:0]       a1, a2;
    logic [11:0]      sum;
    logic [3:0]       cnt;
    logic             above;
    logic [HITS_W-1:0] h_base, hits_new;

    assign a_adv       = r_a_valid && (!r_o_valid || o_res.ready);
    assign i_pix.ready = !r_a_valid || a_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= RST_FRAME_WIDTH;
            r_frame_height   <= RST_FRAME_HEIGHT;
            r_mean_threshold <= RST_MEAN_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[FH_W-1:0];
                CFG_MEAN_THRESHOLD: r_mean_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (r_frame_width == '0) begin
            w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_frame_width);
        end
        h      = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
        h_row  = ROW_W'(h);
        h1_row = h_row + ROW_W'(1);
    end

    // position of the incoming item and the centre it decides
    always_comb begin
        pos_rst  = (32'(r_col) >= 32'(w)) || (r_row > h1_row)
                   || ((r_row == h1_row) && (r_col != '0));
        col_e    = pos_rst ? '0 : r_col;
        row_e    = pos_rst ? '0 : r_row;
        col_zero = (col_e == '0);

        if (col_zero) begin
            x      = COL_W'(32'(w) - 32'd1);
            y_full = row_e - ROW_W'(2);
            n_ctl.decide = (row_e >= ROW_W'(2)) && (row_e <= h1_row);
        end else begin
            x      = col_e - COL_W'(1);
            y_full = row_e - ROW_W'(1);
            n_ctl.decide = (row_e >= ROW_W'(1)) && (row_e <= h_row);
        end

        n_ctl.left     = (x != '0);
        n_ctl.right    = (32'(x) + 32'd1) < 32'(w);
        n_ctl.top      = (y_full != '0);
        n_ctl.bottom   = (32'(y_full) + 32'd1) < 32'(h);
        n_ctl.done     = n_ctl.decide && (32'(x) == 32'(w) - 32'd1)
                         && (32'(y_full) == 32'(h) - 32'd1);
        n_ctl.clr_hits = pos_rst;
        n_ctl.pos_x    = POSX_W'(x);
        n_ctl.pos_y    = POSY_W'(y_full);

        // advance the raster position
        if (n_ctl.done) begin
            n_col = '0;
            n_row = '0;
        end else if ((32'(col_e) + 32'd1) >= 32'(w)) begin
            n_col = '0;
            n_row = row_e + ROW_W'(1);
        end else begin
            n_col = col_e + COL_W'(1);
            n_row = row_e;
        end

        p_in = i_pix.data.is_flush ? 8'd0 : i_pix.data.pixel_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // stage payload; forward the write of the item ahead when it hits the same column
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_p   <= p_in;
            r_a_col <= col_e;
            r_a_ctl <= n_ctl;
            r_a_fwd <= a_adv && (r_a_col == col_e);
            r_a_fa1 <= r_a_p;
            r_a_fa2 <= a1;
        end
    end

    // line buffer memories: read at acceptance, write back when the item leaves stage two
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_a1 <= r_line_above[col_e];
            r_rd_a2 <= r_line_two_above[col_e];
        end
        if (a_adv) begin
            r_line_above[r_a_col]     <= r_a_p;
            r_line_two_above[r_a_col] <= a1;
        end
    end

    // window shift, clipped sum and threshold compare
    always_comb begin
        a1 = r_a_fwd ? r_a_fa1 : r_rd_a1;
        a2 = r_a_fwd ? r_a_fa2 : r_rd_a2;

        for (int r = 0; r < 3; r++) begin
            n_win[0][r] = r_win[1][r];
            n_win[1][r] = r_win[2][r];
        end
        n_win[2][0] = a2;
        n_win[2][1] = a1;
        n_win[2][2] = r_a_p;

        sum = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if ((c != 0 || r_a_ctl.left) && (c != 2 || r_a_ctl.right)
                    && (r != 0 || r_a_ctl.top) && (r != 2 || r_a_ctl.bottom)) begin
                    sum = sum + 12'(n_win[c][r]);
                end
            end
        end
        cnt = (4'd1 + 4'(r_a_ctl.left) + 4'(r_a_ctl.right))
              * (4'd1 + 4'(r_a_ctl.top) + 4'(r_a_ctl.bottom));

        above = r_a_ctl.decide
                && ({sum, 4'b0000} > (16'(r_mean_threshold) * 16'(cnt)));

        h_base   = r_a_ctl.clr_hits ? '0 : r_hits;
        hits_new = (above && h_base != HIT_MAX) ? h_base + HITS_W'(1) : h_base;

        if (r_a_ctl.done) begin
            n_hits = '0;
        end else begin
            n_hits = hits_new;
        end

        n_o = '0;
        if (r_a_ctl.decide) begin
            n_o.decided     = 1'b1;
            n_o.above       = above;
            n_o.pos_x       = r_a_ctl.pos_x;
            n_o.pos_y       = r_a_ctl.pos_y;
            n_o.hits_so_far = hits_new;
            n_o.frame_done  = r_a_ctl.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits    <= '0;
            r_o_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else begin
            if (a_adv) begin
                r_hits <= n_hits;
                r_win  <= n_win;
            end
            if (a_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o <= n_o;
        end
    end

    // a result without a decision carries nothing
    a_undecided_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o.decided) |->
            (!r_o.above && !r_o.frame_done && r_o.hits_so_far == '0
             && r_o.pos_x == '0 && r_o.pos_y == '0))
        else $error("undecided result carries nonzero fields");

    a_done_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o.frame_done) |-> r_o.decided)
        else $error("frame end flagged without a decision");

    // read data must hold while stage two waits
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> ($stable(r_rd_a1) && $stable(r_rd_a2)))
        else $error("line buffer read data changed under a stalled item");

    // hit count restarts after the frame's last decision leaves stage two
    a_hits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_adv && r_a_ctl.done) |=> (r_hits == '0))
        else $error("hit count not cleared at frame end");

endmodule
